// ===== hdl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants for the byte frame decoder: status codes,
// configuration register indexes, sync header reset values and frame layout.
// ----------------------------------------------------------------------------
package bfd_pkg;

  // Frame status reported with every result
  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_INVALID    = 2'd2
  } frame_status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC_BYTE0 = 2'd0,
    CFG_SYNC_BYTE1 = 2'd1,
    CFG_SYNC_BYTE2 = 2'd2,
    CFG_SYNC_BYTE3 = 2'd3
  } cfg_index_t;

  typedef logic [7:0] byte_t;

  // Sync header after reset: "head"
  localparam byte_t SyncByte0Rst = 8'd104;
  localparam byte_t SyncByte1Rst = 8'd101;
  localparam byte_t SyncByte2Rst = 8'd97;
  localparam byte_t SyncByte3Rst = 8'd100;

  // Frame layout: 4 sync, length, seq, type, payload, 2 checksum bytes
  localparam byte_t MinFrameLen  = 8'd9;
  localparam byte_t PayloadStart = 8'd7;
  localparam byte_t PosLength    = 8'd4;
  localparam byte_t PosSeq       = 8'd5;
  localparam byte_t PosType      = 8'd6;

endpackage

// ===== hdl/bfd_stream_if.sv =====
// ----------------------------------------------------------------------------
// bfd_in_if / bfd_out_if
// Valid/ready channels of the frame decoder: received bytes in, one decode
// result per byte out.
// ----------------------------------------------------------------------------
interface bfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bfd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] frame_length;
  logic [7:0] frame_seq;
  logic [7:0] frame_type;

  modport source (
    output valid, output frame_status, output payload_valid, output payload_byte,
    output payload_index, output frame_length, output frame_seq, output frame_type,
    input ready
  );
  modport sink (
    input valid, input frame_status, input payload_valid, input payload_byte,
    input payload_index, input frame_length, input frame_seq, input frame_type,
    output ready
  );
endinterface

// ===== hdl/byte_frame_decoder_additive_checksum.sv =====
// ----------------------------------------------------------------------------
// byte_frame_decoder_additive_checksum
// Length-prefixed frame parser with a 16-bit additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one received byte per transaction. For every byte taken
//   the block produces exactly one transaction on out_chan: frame status,
//   payload byte with its index when the byte was payload, and the length,
//   sequence and type fields of the current (or last) frame.
//   cfg_we/cfg_idx/cfg_wdata set the four expected sync header bytes; write
//   them only while no transaction is in flight.
// Output timing and throughput:
//   The result is registered: it appears on out_chan in the cycle after the
//   byte is taken. One byte per cycle is sustained unless out_chan stalls;
//   the frame state (byte position, running sum) updates as the byte is taken.
// Reset:
//   rst_n (synchronous) clears the frame state and the output valid flag, and
//   restores the sync header to "head"; the block starts out hunting.
// Stall:
//   While out_chan is stalled the pending result holds. A new byte is still
//   taken in the cycle the pending result leaves (in_chan.ready follows
//   out_chan.ready when the output register is full).
// ----------------------------------------------------------------------------
module byte_frame_decoder_additive_checksum (
  input  logic        clk,
  input  logic        rst_n,
  bfd_in_if.sink      in_chan,
  bfd_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  bfd_pkg::byte_t cfg_wdata
);
  import bfd_pkg::*;

  // Configuration registers
  byte_t sync0_r, sync1_r, sync2_r, sync3_r;

  // Frame state
  byte_t       cnt_r, cnt_nxt;
  byte_t       len_r, len_nxt;
  byte_t       seq_r, seq_nxt;
  byte_t       type_r, type_nxt;
  logic [15:0] sum_r, sum_nxt;
  byte_t       chk_hi_r, chk_hi_nxt;

  // Output register
  logic          out_valid_r;
  frame_status_t status_r, status_nxt;
  logic          pvalid_r, pvalid_nxt;
  byte_t         pbyte_r, pbyte_nxt;
  byte_t         pindex_r, pindex_nxt;

  logic  in_fire;
  logic  out_fire;
  byte_t b;
  byte_t want;
  logic [8:0] cnt_p2;

  assign out_fire       = out_valid_r & out_chan.ready;
  assign in_chan.ready  = ~out_valid_r | out_chan.ready;
  assign in_fire        = in_chan.valid & in_chan.ready;
  assign b              = in_chan.rx_byte;
  assign cnt_p2         = {1'b0, cnt_r} + 9'd2;

  // Expected header byte for positions 1 to 3
  always_comb begin
    case (cnt_r[1:0])
      2'd1:    want = sync1_r;
      2'd2:    want = sync2_r;
      default: want = sync3_r;
    endcase
  end

  // Decode of one byte against the frame state
  always_comb begin
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    seq_nxt    = seq_r;
    type_nxt   = type_r;
    sum_nxt    = sum_r;
    chk_hi_nxt = chk_hi_r;
    status_nxt = ST_INCOMPLETE;
    pvalid_nxt = 1'b0;
    pbyte_nxt  = '0;
    pindex_nxt = '0;

    if (cnt_r == 8'd0) begin
      // hunting for the first sync byte
      if (b == sync0_r) begin
        sum_nxt = {8'd0, b};
        cnt_nxt = 8'd1;
      end
    end else if (cnt_r < PosLength) begin
      if (b == want) begin
        sum_nxt = sum_r + {8'd0, b};
        cnt_nxt = cnt_r + 8'd1;
      end else begin
        status_nxt = ST_INVALID;
        cnt_nxt    = '0;
      end
    end else if (cnt_r == PosLength) begin
      len_nxt = b;
      if (b < MinFrameLen) begin
        status_nxt = ST_INVALID;
        cnt_nxt    = '0;
      end else begin
        sum_nxt = sum_r + {8'd0, b};
        cnt_nxt = PosSeq;
      end
    end else if (cnt_r == PosSeq) begin
      seq_nxt = b;
      sum_nxt = sum_r + {8'd0, b};
      cnt_nxt = PosType;
    end else if (cnt_r == PosType) begin
      type_nxt = b;
      sum_nxt  = sum_r + {8'd0, b};
      cnt_nxt  = PayloadStart;
    end else if (cnt_p2 < {1'b0, len_r}) begin
      // payload byte
      pvalid_nxt = 1'b1;
      pbyte_nxt  = b;
      pindex_nxt = cnt_r - PayloadStart;
      sum_nxt    = sum_r + {8'd0, b};
      cnt_nxt    = cnt_r + 8'd1;
    end else if (cnt_p2 == {1'b0, len_r}) begin
      chk_hi_nxt = b;
      cnt_nxt    = cnt_r + 8'd1;
    end else begin
      // low checksum byte closes the frame
      status_nxt = ({chk_hi_r, b} == sum_r) ? ST_COMPLETE : ST_INVALID;
      cnt_nxt    = '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync0_r <= SyncByte0Rst;
      sync1_r <= SyncByte1Rst;
      sync2_r <= SyncByte2Rst;
      sync3_r <= SyncByte3Rst;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_idx))
        CFG_SYNC_BYTE0: sync0_r <= cfg_wdata;
        CFG_SYNC_BYTE1: sync1_r <= cfg_wdata;
        CFG_SYNC_BYTE2: sync2_r <= cfg_wdata;
        CFG_SYNC_BYTE3: sync3_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame state, updated as each byte is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      len_r    <= '0;
      seq_r    <= '0;
      type_r   <= '0;
      sum_r    <= '0;
      chk_hi_r <= '0;
    end else if (in_fire) begin
      cnt_r    <= cnt_nxt;
      len_r    <= len_nxt;
      seq_r    <= seq_nxt;
      type_r   <= type_nxt;
      sum_r    <= sum_nxt;
      chk_hi_r <= chk_hi_nxt;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      pvalid_r <= pvalid_nxt;
      pbyte_r  <= pbyte_nxt;
      pindex_r <= pindex_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.frame_status  = status_r;
  assign out_chan.payload_valid = pvalid_r;
  assign out_chan.payload_byte  = pbyte_r;
  assign out_chan.payload_index = pindex_r;
  assign out_chan.frame_length  = len_r;
  assign out_chan.frame_seq     = seq_r;
  assign out_chan.frame_type    = type_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Inside the payload/checksum area the length was accepted and bounds us
  a_cnt_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > PosType) |-> (len_r >= MinFrameLen && cnt_r < len_r))
    else $error("byte position outside the frame length");

  // A payload result never carries a final status
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && pvalid_r) |-> (status_r == ST_INCOMPLETE))
    else $error("payload byte reported with a final status");

  // A final status always sends the decoder back to hunting
  a_final_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && status_nxt != ST_INCOMPLETE) |=> (cnt_r == 8'd0))
    else $error("decoder not hunting after frame end");

  // Output register cannot be overwritten while a result is pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !in_fire)
    else $error("byte taken while result stalled");

endmodule

// ===== bench/byte_frame_decoder_additive_checksum_tb.sv =====
// ----------------------------------------------------------------------------
// byte_frame_decoder_additive_checksum_tb
// Self-checking bench for the frame decoder. A short table of directed bytes
// (hunting, header slips, short length, minimum and payload frames, good and
// bad checksums) is followed by random frames under several sync headers and
// idle/stall mixes. Every result transaction is checked field by field against
// its pinned row or a behavioral decoder kept in step with accepted bytes.
// ----------------------------------------------------------------------------
module byte_frame_decoder_additive_checksum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfd_pkg::*;

  localparam int ClkHalf       = 5;
  localparam int ResetCycles   = 6;
  localparam int WatchdogLimit = 5000;
  localparam int NumSegments   = 6;
  localparam int ItemsPerSeg   = 120;
  localparam int TailCycles    = 8;
  localparam int MaxFrameLen   = 255;

  // One decode result, as seen on out_chan
  typedef struct packed {
    frame_status_t status;
    logic          pay_valid;
    byte_t         pay_byte;
    byte_t         pay_index;
    byte_t         length;
    byte_t         seq;
    byte_t         ftype;
  } decode_t;

  // Directed table row: byte to send and, where pinned, the typed result
  typedef struct packed {
    byte_t   rx;
    logic    pinned;
    decode_t res;
  } probe_t;

  localparam decode_t Hunting = '0;
  localparam decode_t HdrBad  = '{ST_INVALID, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

  // Default header is "head" = 68 65 61 64
  localparam probe_t DirRows [28] = '{
    // hunting: non-sync bytes, sync slip at position 1, slip byte not retried
    '{8'h00, 1'b1, Hunting},
    '{8'h68, 1'b1, Hunting},
    '{8'hFF, 1'b1, HdrBad},
    '{8'h65, 1'b1, Hunting},
    // length just below the minimum
    '{8'h68, 1'b0, Hunting},
    '{8'h65, 1'b0, Hunting},
    '{8'h61, 1'b0, Hunting},
    '{8'h64, 1'b0, Hunting},
    '{8'h08, 1'b1, '{ST_INVALID, 1'b0, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00}},
    // minimum frame, no payload, good checksum 0x029A
    '{8'h68, 1'b0, Hunting},
    '{8'h65, 1'b0, Hunting},
    '{8'h61, 1'b0, Hunting},
    '{8'h64, 1'b0, Hunting},
    '{8'h09, 1'b0, Hunting},
    '{8'h00, 1'b0, Hunting},
    '{8'hFF, 1'b0, Hunting},
    '{8'h02, 1'b0, Hunting},
    '{8'h9A, 1'b1, '{ST_COMPLETE, 1'b0, 8'h00, 8'h00, 8'h09, 8'h00, 8'hFF}},
    // one payload byte, checksum off by one (0x02A2 sent as 0x02A3)
    '{8'h68, 1'b0, Hunting},
    '{8'h65, 1'b0, Hunting},
    '{8'h61, 1'b0, Hunting},
    '{8'h64, 1'b0, Hunting},
    '{8'h0A, 1'b0, Hunting},
    '{8'h00, 1'b0, Hunting},
    '{8'h07, 1'b0, Hunting},
    '{8'hFF, 1'b1, '{ST_INCOMPLETE, 1'b1, 8'hFF, 8'h00, 8'h0A, 8'h00, 8'h07}},
    '{8'h02, 1'b0, Hunting},
    '{8'hA3, 1'b1, '{ST_INVALID, 1'b0, 8'h00, 8'h00, 8'h0A, 8'h00, 8'h07}}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  byte_t      cfg_wdata;

  bfd_in_if  in_ch ();
  bfd_out_if out_ch ();

  byte_frame_decoder_additive_checksum u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Behavioral decoder state
  byte_t       sync_hdr [4];
  byte_t       dec_pos;
  byte_t       dec_len;
  byte_t       dec_seq;
  byte_t       dec_type;
  logic [15:0] dec_sum;
  byte_t       dec_chk_hi;

  decode_t expected_decodes [$];
  int      error_count;
  int      quiet_cycles;
  int      sent_count;
  int      src_idle_pct;
  int      snk_idle_pct;

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // Decode one accepted byte and advance the frame state
  task decode_rx_byte(input byte_t b, output decode_t r);
    r = Hunting;
    if (dec_pos == 8'd0) begin
      if (b == sync_hdr[0]) begin
        dec_sum = {8'h00, b};
        dec_pos = 8'd1;
      end
    end else if (dec_pos < PosLength) begin
      if (b == sync_hdr[dec_pos[1:0]]) begin
        dec_sum += b;
        dec_pos++;
      end else begin
        r.status = ST_INVALID;
        dec_pos  = 8'd0;
      end
    end else if (dec_pos == PosLength) begin
      dec_len = b;
      if (b < MinFrameLen) begin
        r.status = ST_INVALID;
        dec_pos  = 8'd0;
      end else begin
        dec_sum += b;
        dec_pos  = PosSeq;
      end
    end else if (dec_pos == PosSeq) begin
      dec_seq  = b;
      dec_sum += b;
      dec_pos  = PosType;
    end else if (dec_pos == PosType) begin
      dec_type = b;
      dec_sum += b;
      dec_pos  = PayloadStart;
    end else if (int'(dec_pos) + 2 < int'(dec_len)) begin
      r.pay_valid = 1'b1;
      r.pay_byte  = b;
      r.pay_index = dec_pos - PayloadStart;
      dec_sum    += b;
      dec_pos++;
    end else if (int'(dec_pos) + 2 == int'(dec_len)) begin
      dec_chk_hi = b;
      dec_pos++;
    end else begin
      // low checksum byte closes the frame
      r.status = ({dec_chk_hi, b} == dec_sum) ? ST_COMPLETE : ST_INVALID;
      dec_pos  = 8'd0;
    end
    r.length = dec_len;
    r.seq    = dec_seq;
    r.ftype  = dec_type;
  endtask

  task check_decode(input decode_t want, input decode_t got);
    if (got.status !== want.status) begin
      $error("frame_status: expected %0d, got %0d", want.status, got.status);
      error_count++;
    end
    if (got.pay_valid !== want.pay_valid) begin
      $error("payload_valid: expected %0d, got %0d", want.pay_valid, got.pay_valid);
      error_count++;
    end
    if (got.pay_byte !== want.pay_byte) begin
      $error("payload_byte: expected %0h, got %0h", want.pay_byte, got.pay_byte);
      error_count++;
    end
    if (got.pay_index !== want.pay_index) begin
      $error("payload_index: expected %0d, got %0d", want.pay_index, got.pay_index);
      error_count++;
    end
    if (got.length !== want.length) begin
      $error("frame_length: expected %0d, got %0d", want.length, got.length);
      error_count++;
    end
    if (got.seq !== want.seq) begin
      $error("frame_seq: expected %0h, got %0h", want.seq, got.seq);
      error_count++;
    end
    if (got.ftype !== want.ftype) begin
      $error("frame_type: expected %0h, got %0h", want.ftype, got.ftype);
      error_count++;
    end
  endtask

  // Send one byte; on acceptance queue its expected result
  task send_byte(input byte_t b, input logic pinned, input decode_t typed);
    decode_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    decode_rx_byte(b, pred);
    expected_decodes.push_back(pinned ? typed : pred);
    sent_count++;
  endtask

  // Hold the sender until every queued result has come back
  task drain_results;
    in_ch.valid <= 1'b0;
    while (expected_decodes.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task cfg_write(input cfg_index_t idx, input byte_t v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sync_hdr[idx] = v;
  endtask

  task load_sync_hdr(input byte_t b0, input byte_t b1, input byte_t b2, input byte_t b3);
    cfg_write(CFG_SYNC_BYTE0, b0);
    cfg_write(CFG_SYNC_BYTE1, b1);
    cfg_write(CFG_SYNC_BYTE2, b2);
    cfg_write(CFG_SYNC_BYTE3, b3);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed frames; the rest bad checksum, short length,
  // header slip or line noise. fixed_len forces a good frame of that length.
  task send_random_frame(input int fixed_len);
    byte_t       fb [$];
    int          pick;
    int          flen;
    int          slip;
    logic [15:0] sum;
    byte_t       b;
    pick = (fixed_len != 0) ? 0 : $urandom_range(0, 99);
    fb.push_back(sync_hdr[0]);
    if (pick < 70) begin
      if (fixed_len != 0) flen = fixed_len;
      else if ($urandom_range(0, 99) < 94) flen = $urandom_range(MinFrameLen, 20);
      else flen = $urandom_range(21, MaxFrameLen - 1);
      fb.push_back(sync_hdr[1]);
      fb.push_back(sync_hdr[2]);
      fb.push_back(sync_hdr[3]);
      fb.push_back(byte_t'(flen));
      repeat (flen - 7) fb.push_back(byte_t'($urandom_range(0, 255)));
      sum = '0;
      foreach (fb[i]) sum += fb[i];
      fb.push_back(sum[15:8]);
      fb.push_back(sum[7:0]);
      // corrupt one checksum byte
      if (pick >= 60) fb[fb.size() - 1 - $urandom_range(0, 1)] ^= byte_t'($urandom_range(1, 255));
    end else if (pick < 78) begin
      fb.push_back(sync_hdr[1]);
      fb.push_back(sync_hdr[2]);
      fb.push_back(sync_hdr[3]);
      fb.push_back(byte_t'($urandom_range(0, MinFrameLen - 1)));
    end else if (pick < 88) begin
      slip = $urandom_range(1, 3);
      for (int k = 1; k < slip; k++) fb.push_back(sync_hdr[k]);
      do b = byte_t'($urandom_range(0, 255)); while (b == sync_hdr[slip]);
      fb.push_back(b);
    end else begin
      fb.delete();
      repeat ($urandom_range(1, 6)) fb.push_back(byte_t'($urandom_range(0, 255)));
    end
    foreach (fb[i]) send_byte(fb[i], 1'b0, Hunting);
  endtask

  // Result side: random stall
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Result checker and watchdog
  always @(posedge clk) begin
    decode_t got;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        got = '{frame_status_t'(out_ch.frame_status), out_ch.payload_valid,
                out_ch.payload_byte, out_ch.payload_index, out_ch.frame_length,
                out_ch.frame_seq, out_ch.frame_type};
        if (expected_decodes.size() == 0) begin
          $error("result transaction with no byte pending: status %0d", got.status);
          error_count++;
        end else begin
          check_decode(expected_decodes.pop_front(), got);
        end
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_SYNC_BYTE0;
    cfg_wdata     = 8'h00;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    error_count   = 0;
    quiet_cycles  = 0;
    sent_count    = 0;
    src_idle_pct  = 0;
    snk_idle_pct  = 0;
    sync_hdr      = '{SyncByte0Rst, SyncByte1Rst, SyncByte2Rst, SyncByte3Rst};
    dec_pos       = 8'd0;
    dec_len       = 8'd0;
    dec_seq       = 8'd0;
    dec_type      = 8'd0;
    dec_sum       = 16'd0;
    dec_chk_hi    = 8'd0;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    src_idle_pct = 33;
    snk_idle_pct = 88;
    foreach (DirRows[i]) send_byte(DirRows[i].rx, DirRows[i].pinned, DirRows[i].res);

    // random segments: header reloaded each time, idle mix changes every two
    for (int seg = 0; seg < NumSegments; seg++) begin
      drain_results();
      case (seg)
        0: load_sync_hdr(SyncByte0Rst, SyncByte1Rst, SyncByte2Rst, SyncByte3Rst);
        2: load_sync_hdr(8'h00, 8'h00, 8'h00, 8'h00);
        4: load_sync_hdr(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        default: load_sync_hdr(byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)),
                               byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)));
      endcase
      case (seg / 2)
        0: begin
          src_idle_pct = 33;
          snk_idle_pct = 88;
        end
        1: begin
          src_idle_pct = 88;
          snk_idle_pct = 33;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      sent_count = 0;
      if (seg == 1 || seg == 4) send_random_frame(MaxFrameLen);
      while (sent_count < ItemsPerSeg) begin
        if ($urandom_range(0, 99) < 3) drain_results();
        send_random_frame(0);
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
